FILE: rtl/tspbm_pkg.sv
// Package for the bitmask tour solver: beat types and fixed field widths.
// Used by tsp_bitmask_min_tour; no dependencies.
package tspbm_pkg;

    localparam int unsigned CITY_W   = 4;
    localparam int unsigned FIELD_WW = 8;
    localparam int unsigned COST_W   = 12;
    localparam logic [COST_W-1:0] COST_LIMIT = 12'hFFF;

    // Command codes of an input beat.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [CITY_W-1:0]   from_city;
        logic [CITY_W-1:0]   to_city;
        logic [FIELD_WW-1:0] weight;
    } t_in_beat;

    typedef struct packed {
        logic [COST_W-1:0] tour_cost;
        logic              no_tour;
    } t_out_beat;

endpackage

FILE: rtl/tspbm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tspbm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/tsp_bitmask_min_tour.sv
// Load beats are accepted one per cycle, back to back, while idle.
// A start beat fills the cost table for the n cities in use; the input stalls until the
// result is loaded into the output register, and longer while that register is stalled.
// Every (mask, city) pair reads all n candidate next cities and writes once; the last mask has one city only.
// Synchronous active-low reset clears control state and sets city_count to 4; RAM
// contents are left as they are.
module tsp_bitmask_min_tour #(
    parameter int unsigned MAX_CITIES  = 12,
    parameter int unsigned WEIGHT_BITS = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    input  tspbm_pkg::t_in_beat                     i_in_data,
    output logic                                    o_in_stall,
    output logic                                    o_out_valid,
    output tspbm_pkg::t_out_beat                    o_out_data,
    input  logic                                    i_out_stall,
    input  logic                                    i_cfg_we,
    input  logic [tspbm_pkg::CITY_W-1:0]            i_cfg_data
);

    localparam int unsigned NB     = $clog2(MAX_CITIES);
    localparam int unsigned CW     = WEIGHT_BITS + NB;
    localparam int unsigned EW     = (CW > tspbm_pkg::COST_W) ? CW : tspbm_pkg::COST_W;
    localparam int unsigned WXW    = (WEIGHT_BITS > tspbm_pkg::FIELD_WW) ?
                                     WEIGHT_BITS : tspbm_pkg::FIELD_WW;
    localparam int unsigned W_DEPTH = 1 << (2 * NB);
    localparam int unsigned C_DEPTH = 1 << (MAX_CITIES + NB);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_RUN    = 4'b0010,
        S_WRITE  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state                          r_state;
    logic [tspbm_pkg::CITY_W-1:0]    r_city_count;
    logic [MAX_CITIES-1:0]           r_mask;
    logic [MAX_CITIES-1:0]           r_full;
    logic [NB-1:0]                   r_node;
    logic [NB-1:0]                   r_nxt;
    logic [NB-1:0]                   r_n_m1;
    logic                            r_p_valid;
    logic [NB-1:0]                   r_p_nxt;
    logic                            r_p_inmask;
    logic [CW-1:0]                   r_acc;
    logic                            r_acc_none;
    logic [CW-1:0]                   r_res_cost;
    logic                            r_res_none;
    logic                            r_out_valid;
    tspbm_pkg::t_out_beat            r_out_data;

    logic                            in_accept;
    logic                            load_ok;
    logic [NB:0]                     n_used;
    logic [MAX_CITIES-1:0]           full_calc;
    logic [WXW-1:0]                  w_ext;
    logic [WEIGHT_BITS-1:0]          w_rdata;
    logic [CW:0]                     c_rdata;
    logic [CW-1:0]                   cand;
    logic                            cand_ok;
    logic                            better;
    logic [CW-1:0]                   upd_cost;
    logic                            upd_none;
    logic                            is_full;
    logic [MAX_CITIES-1:0]           nxt_bit;
    logic [EW-1:0]                   res_ext;
    logic                            out_free;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign load_ok = in_accept && (i_in_data.cmd == tspbm_pkg::CMD_LOAD) &&
                     (int'(i_in_data.from_city) < MAX_CITIES) &&
                     (int'(i_in_data.to_city) < MAX_CITIES);
    assign w_ext = WXW'(i_in_data.weight);

    // Clamp the configured city count into 1..MAX_CITIES and build the full mask.
    always_comb begin
        if (r_city_count == '0) begin
            n_used = (NB+1)'(1);
        end else if (int'(r_city_count) > MAX_CITIES) begin
            n_used = (NB+1)'(MAX_CITIES);
        end else begin
            n_used = (NB+1)'(r_city_count);
        end
        for (int i = 0; i < MAX_CITIES; i++) begin
            full_calc[i] = (i < int'(n_used));
        end
    end

    // Weight store, addressed by {from, to}.
    tspbm_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (W_DEPTH)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (load_ok),
        .i_waddr ({NB'(i_in_data.from_city), NB'(i_in_data.to_city)}),
        .i_wdata (WEIGHT_BITS'(w_ext)),
        .i_raddr ({r_node, r_nxt}),
        .o_rdata (w_rdata)
    );

    // Cost table, addressed by {mask, city}; top bit marks "no path".
    assign nxt_bit = MAX_CITIES'(1) << r_nxt;

    tspbm_ram #(
        .WIDTH (CW + 1),
        .DEPTH (C_DEPTH)
    ) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WRITE),
        .i_waddr ({r_mask, r_node}),
        .i_wdata ({upd_none, upd_cost}),
        .i_raddr ({r_mask | nxt_bit, r_nxt}),
        .o_rdata (c_rdata)
    );

    // Fold the candidate that arrives this cycle into the running minimum.
    always_comb begin
        is_full = (r_mask == r_full);
        if (is_full) begin
            cand    = CW'(w_rdata);
            cand_ok = r_p_valid && (w_rdata != '0) && (r_p_nxt == '0);
        end else begin
            cand    = CW'(w_rdata) + c_rdata[CW-1:0];
            cand_ok = r_p_valid && (w_rdata != '0) && !r_p_inmask && !c_rdata[CW];
        end
        better   = cand_ok && (r_acc_none || (cand < r_acc));
        upd_cost = better ? cand : r_acc;
        upd_none = better ? 1'b0 : r_acc_none;
    end

    // Main sequencer: mask descending, city, then candidate next city.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_p_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_p_valid <= 1'b0;
                    if (in_accept && (i_in_data.cmd == tspbm_pkg::CMD_START)) begin
                        r_n_m1     <= NB'(n_used - 1'b1);
                        r_full     <= full_calc;
                        r_mask     <= full_calc;
                        r_node     <= '0;
                        r_nxt      <= '0;
                        r_acc      <= '0;
                        r_acc_none <= 1'b1;
                        r_state    <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_p_valid  <= 1'b1;
                    r_p_nxt    <= r_nxt;
                    r_p_inmask <= r_mask[r_nxt];
                    r_acc      <= upd_cost;
                    r_acc_none <= upd_none;
                    if (r_nxt == r_n_m1) begin
                        r_nxt   <= '0;
                        r_state <= S_WRITE;
                    end else begin
                        r_nxt <= r_nxt + 1'b1;
                    end
                end
                S_WRITE: begin
                    r_p_valid  <= 1'b0;
                    r_acc      <= '0;
                    r_acc_none <= 1'b1;
                    if ((r_mask == MAX_CITIES'(1)) && (r_node == '0)) begin
                        r_res_cost <= upd_cost;
                        r_res_none <= upd_none;
                        r_state    <= S_FINISH;
                    end else begin
                        if (r_node == r_n_m1) begin
                            r_node <= '0;
                            r_mask <= r_mask - 1'b1;
                        end else begin
                            r_node <= r_node + 1'b1;
                        end
                        r_state <= S_RUN;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_city_count <= 4'd4;
        end else if (i_cfg_we) begin
            r_city_count <= i_cfg_data;
        end
    end

    // Output register; the result beat waits here until taken.
    assign out_free = !r_out_valid || !i_out_stall;
    assign res_ext  = EW'(r_res_cost);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FINISH) && out_free) begin
            r_out_valid <= 1'b1;
            r_out_data.no_tour <= r_res_none;
            if (r_res_none) begin
                r_out_data.tour_cost <= '0;
            end else if (res_ext > EW'(tspbm_pkg::COST_LIMIT)) begin
                r_out_data.tour_cost <= tspbm_pkg::COST_LIMIT;
            end else begin
                r_out_data.tour_cost <= tspbm_pkg::COST_W'(res_ext);
            end
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The weight store is only written while idle.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_ok |-> (r_state == S_IDLE))
        else $error("weight write outside idle");

    // The mask never reaches zero while the table is being filled.
    a_mask_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN || r_state == S_WRITE) |-> (r_mask != '0))
        else $error("mask underflow");

    // A result is only produced right after the final table write.
    a_finish_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_FINISH) |-> $past(r_state == S_WRITE))
        else $error("finish entered from wrong state");

    // A new result is only loaded when the output register is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_data)))
        else $error("result overwritten");

endmodule

FILE: tb/tspbm_tour_checker.sv
// Checker for the bitmask tour solver: watches the input, output and config channels.
// It predicts each tour result and compares it with the output beats.
// Depends on tspbm_pkg for the beat types.
`timescale 1ns / 100ps

module tspbm_tour_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  tspbm_pkg::t_in_beat  i_in_data,
    input  logic                 i_in_stall,
    input  logic                 i_out_valid,
    input  tspbm_pkg::t_out_beat i_out_data,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_we,
    input  logic [3:0]           i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int NCITY   = 12;
    localparam int NO_PATH = 32'h3FFF_FFFF;

    logic [7:0]  edge_wt [NCITY][NCITY];
    logic [3:0]  city_cnt;
    int          finish_cost [4096*NCITY];
    tspbm_pkg::t_out_beat tour_q [$];

    // Held-Karp fill over visited masks in descending order.
    function automatic tspbm_pkg::t_out_beat predict_tour();
        int        n;
        int        full;
        int        m;
        int        c;
        int        nx;
        int        best;
        int        w;
        int        rest;
        tspbm_pkg::t_out_beat r;
        n = (city_cnt == 0) ? 1 : (city_cnt > NCITY) ? NCITY : int'(city_cnt);
        full = (1 << n) - 1;
        for (m = full; m >= 0; m--) begin
            for (c = 0; c < n; c++) begin
                best = NO_PATH;
                if (m == full) begin
                    w = edge_wt[c][0];
                    if (w != 0) best = w;
                end else begin
                    for (nx = 0; nx < n; nx++) begin
                        w = edge_wt[c][nx];
                        if (m[nx] || w == 0) continue;
                        rest = finish_cost[(m | (1 << nx)) * NCITY + nx];
                        if (rest == NO_PATH) continue;
                        if (w + rest < best) best = w + rest;
                    end
                end
                finish_cost[m * NCITY + c] = best;
            end
        end
        best = finish_cost[NCITY];
        if (best == NO_PATH) begin
            r.tour_cost = '0;
            r.no_tour   = 1'b1;
        end else begin
            r.tour_cost = (best > 4095) ? tspbm_pkg::COST_LIMIT : best[11:0];
            r.no_tour   = 1'b0;
        end
        return r;
    endfunction

    assign o_pending = tour_q.size();

    // Track config, apply loads, predict on starts and compare output beats.
    always @(posedge i_clk) begin
        tspbm_pkg::t_out_beat want;
        if (!i_rst_n) begin
            city_cnt     <= 4'd4;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) city_cnt <= i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.cmd == tspbm_pkg::CMD_LOAD) begin
                    if (i_in_data.from_city < NCITY && i_in_data.to_city < NCITY)
                        edge_wt[i_in_data.from_city][i_in_data.to_city] = i_in_data.weight;
                end else begin
                    tour_q.push_back(predict_tour());
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (tour_q.size() == 0) begin
                    $display("%0t: unexpected beat cost=%0d no_tour=%0b", $time,
                             i_out_data.tour_cost, i_out_data.no_tour);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = tour_q.pop_front();
                    if (want.tour_cost !== i_out_data.tour_cost ||
                        want.no_tour !== i_out_data.no_tour) begin
                        $display("%0t: expected cost=%0d no_tour=%0b, got cost=%0d no_tour=%0b",
                                 $time, want.tour_cost, want.no_tour,
                                 i_out_data.tour_cost, i_out_data.no_tour);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/tb_tsp_bitmask_min_tour.sv
// Testbench top for tsp_bitmask_min_tour: weight loads, tour starts and config changes.
// Depends on tspbm_pkg, the block and tspbm_tour_checker.
`timescale 1ns / 100ps

module tb_tsp_bitmask_min_tour;

    localparam int CYCLE_LIMIT = 5000000;
    localparam int ITEM_TARGET = 1750;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    tspbm_pkg::t_in_beat  in_data = '0;
    logic      in_stall;
    logic      out_valid;
    tspbm_pkg::t_out_beat out_data;
    logic      out_stall = 1'b0;
    logic      cfg_we = 1'b0;
    logic [3:0] cfg_data = 4'd0;
    int        fail_count;
    int        pending;
    int        items_sent = 0;
    int        starts_sent = 0;
    int        tours_seen = 0;
    int        cycles = 0;
    bit        quiet = 1'b0;
    bit        hold_done = 1'b0;
    int        hold_left = 0;
    int        burst_left = 0;

    tsp_bitmask_min_tour dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    tspbm_tour_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_data    (in_data),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_data   (out_data),
        .i_out_stall  (out_stall),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) tours_seen <= tours_seen + 1;
    end

    // Output stall: random bursts, one long hold-off, and none at the end.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= (hold_left != 1);
        end else if (!hold_done && items_sent >= 200) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            out_stall <= 1'b1;
        end else if (quiet) begin
            out_stall <= 1'b0;
        end else if (burst_left > 0) begin
            burst_left <= burst_left - 1;
        end else begin
            out_stall  <= ($urandom_range(0, 2) == 0);
            burst_left <= $urandom_range(1, 8) - 1;
        end
    end

    // Offer one beat, with an optional random gap first, and wait for acceptance.
    task automatic send_beat(input tspbm_pkg::t_in_beat b);
        bit ok;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do begin
            @(negedge i_clk);
            ok = !in_stall;
            @(posedge i_clk);
        end while (!ok);
        items_sent++;
        if (b.cmd == tspbm_pkg::CMD_START) starts_sent++;
    endtask

    task automatic load_wt(input int from, input int to, input int w);
        tspbm_pkg::t_in_beat b;
        b.cmd       = tspbm_pkg::CMD_LOAD;
        b.from_city = from[3:0];
        b.to_city   = to[3:0];
        b.weight    = w[7:0];
        send_beat(b);
    endtask

    task automatic start_tour();
        tspbm_pkg::t_in_beat b;
        b           = tspbm_pkg::t_in_beat'($urandom());
        b.cmd       = tspbm_pkg::CMD_START;
        send_beat(b);
    endtask

    // Wait until every tour result is back, then write the city count.
    task automatic set_cities(input int n);
        in_valid <= 1'b0;
        while (tours_seen != starts_sent) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= n[3:0];
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Load every entry in use; zero_pct sets how many edges are missing.
    task automatic load_matrix(input int n, input int zero_pct);
        int a;
        int c;
        for (a = 0; a < n; a++)
            for (c = 0; c < n; c++)
                load_wt(a, c, ($urandom_range(0, 99) < zero_pct) ? 0 :
                        $urandom_range(1, 255));
    endtask

    initial begin
        int n;
        int eff;
        int zp;
        int k;
        int j;
        int r;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single city: self edge present, absent, and a zero count acting as one.
        set_cities(1);
        load_wt(0, 0, 7);
        start_tour();
        load_wt(0, 0, 0);
        start_tour();
        set_cities(0);
        load_wt(0, 0, 255);
        start_tour();
        // Loads outside the matrix are ignored.
        load_wt(15, 0, 0);
        load_wt(0, 12, 0);
        load_wt(12, 15, 0);
        start_tour();
        // Two cities at the largest weights.
        set_cities(2);
        load_wt(0, 0, 1);
        load_wt(0, 1, 255);
        load_wt(1, 0, 255);
        load_wt(1, 1, 1);
        start_tour();
        // Three cities with no edge back to the start.
        set_cities(3);
        for (j = 0; j < 9; j++) load_wt(j / 3, j % 3, (j % 3 == 0 && j != 0) ? 0 : j + 1);
        start_tour();

        // Largest count, written out of range so that it clamps.
        set_cities(15);
        load_matrix(12, 5);
        start_tour();

        // Random phases of mostly small tours.
        while (items_sent < ITEM_TARGET) begin
            if (items_sent > ITEM_TARGET - 250) quiet = 1'b1;
            r = $urandom_range(0, 99);
            n = (r < 10) ? $urandom_range(0, 2) : (r < 85) ? $urandom_range(3, 5) :
                $urandom_range(6, 7);
            eff = (n == 0) ? 1 : n;
            zp = ($urandom_range(0, 3) == 0) ? 50 : 8;
            set_cities(n);
            load_matrix(eff, zp);
            k = $urandom_range(1, 3);
            repeat (k) begin
                repeat ($urandom_range(0, 3)) begin
                    if ($urandom_range(0, 5) == 0)
                        load_wt($urandom_range(12, 15), $urandom_range(0, 15), $urandom());
                    else
                        load_wt($urandom_range(0, eff - 1), $urandom_range(0, eff - 1),
                                ($urandom_range(0, 99) < zp) ? 0 : $urandom_range(1, 255));
                end
                start_tour();
            end
        end

        in_valid <= 1'b0;
        while (tours_seen != starts_sent) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: tsp_bitmask_min_tour.f
rtl/tspbm_pkg.sv
rtl/tspbm_ram.sv
rtl/tsp_bitmask_min_tour.sv
tb/tspbm_tour_checker.sv
tb/tb_tsp_bitmask_min_tour.sv
